// ----- rtl/core/cascaded_position_speed_pid_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded position/speed PID block
// Concurrent assertion wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_POSITION_SPEED_PID_MACROS_SVH
`define CASCADED_POSITION_SPEED_PID_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CPSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CPSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared types and constants of the cascaded position/speed PID block.
// ----------------------------------------------------------------------------
package cpsp_pkg;

  // Field and register widths
  localparam int GAIN_W    = 22;
  localparam int BAND_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = 33;
  localparam int DIFF_W    = 34;
  localparam int PSUM_W    = 16;
  localparam int SSUM_W    = 11;
  localparam int CUR_W     = 15;
  localparam int ACC_W     = 58;
  localparam int CHUNK_W   = 17;
  localparam int PROD_W    = GAIN_W + 1 + CHUNK_W + 1;

  // Loop limits
  localparam int POS_INT_LIM = 20000;
  localparam int POS_OUT_LIM = 14000;
  localparam int SPD_INT_LIM = 1000;
  localparam int SPD_OUT_LIM = 16000;
  localparam int CUR_LIM     = 10000;

  // Register reset values
  localparam logic [GAIN_W-1:0] POS_KP_RST   = 22'd6554;
  localparam logic [GAIN_W-1:0] POS_KI_RST   = 22'd0;
  localparam logic [GAIN_W-1:0] POS_KD_RST   = 22'd0;
  localparam logic [BAND_W-1:0] POS_BAND_RST = 16'd100;
  localparam logic [GAIN_W-1:0] SPD_KP_RST   = 22'd524288;
  localparam logic [GAIN_W-1:0] SPD_KI_RST   = 22'd0;
  localparam logic [GAIN_W-1:0] SPD_KD_RST   = 22'd0;
  localparam logic [BAND_W-1:0] SPD_BAND_RST = 16'd10;

  // Last multiply step: three terms, low and high half each
  localparam logic [2:0] MAC_LAST = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_KP   = 3'd0,
    REG_POS_KI   = 3'd1,
    REG_POS_KD   = 3'd2,
    REG_POS_BAND = 3'd3,
    REG_SPD_KP   = 3'd4,
    REG_SPD_KI   = 3'd5,
    REG_SPD_KD   = 3'd6,
    REG_SPD_BAND = 3'd7
  } cpsp_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_BAND,
    S_MAC,
    S_SCALE,
    S_FINISH
  } cpsp_state_e;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } cpsp_term_e;

  typedef struct packed {
    logic       load_err;
    logic       apply_band;
    logic       mac_en;
    logic       mac_first;
    cpsp_term_e term;
    logic       hi;
    logic       scale;
    logic       spd_loop;
    logic       deliver;
  } cpsp_ctrl_t;

endpackage

// ----- rtl/core/cpsp_mac.sv -----
// ----------------------------------------------------------------------------
// cpsp_mac
// Shared multiply-accumulate unit: gain times one 17-bit half of an operand.
// ----------------------------------------------------------------------------
module cpsp_mac import cpsp_pkg::*; (
  input  logic                       clk_i,
  input  cpsp_ctrl_t                 ctrl_i,
  input  logic        [GAIN_W-1:0]   gain_i,
  input  logic signed [DIFF_W-1:0]   operand_i,
  output logic signed [ACC_W-1:0]    acc_o
);

  logic signed [GAIN_W:0]    gain_s;
  logic signed [CHUNK_W:0]   chunk_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   acc_d, acc_q;

  // Pick the unsigned low half or the signed high half
  assign gain_s  = $signed({1'b0, gain_i});
  assign chunk_s = ctrl_i.hi ? $signed({operand_i[DIFF_W-1], operand_i[DIFF_W-1:CHUNK_W]})
                             : $signed({1'b0, operand_i[CHUNK_W-1:0]});
  assign prod    = gain_s * chunk_s;

  // Weight the high half and accumulate
  assign prod_x = ctrl_i.hi ? (ACC_W'(prod) <<< CHUNK_W) : ACC_W'(prod);
  assign acc_d  = ctrl_i.mac_first ? prod_x : acc_q + prod_x;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac_en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/core/cpsp_seq.sv -----
// ----------------------------------------------------------------------------
// cpsp_seq
// Sequencer: error, dead band, six multiply steps and scaling per loop.
// ----------------------------------------------------------------------------
module cpsp_seq import cpsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       in_range_i,
  input  logic       op_i,
  input  logic       out_free_i,
  output cpsp_ctrl_t ctrl_o,
  output logic       busy_o
);

  cpsp_state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic        spd_q, spd_d;

  // Hold state, step and loop select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      spd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      spd_q   <= spd_d;
    end
  end

  // Advance through the loop steps
  always_comb begin
    state_d          = state_q;
    step_d           = step_q;
    spd_d            = spd_q;
    ctrl_o           = '0;
    ctrl_o.spd_loop  = spd_q;
    ctrl_o.term      = cpsp_term_e'(step_q[2:1]);
    ctrl_o.hi        = step_q[0];
    ctrl_o.mac_first = (step_q == 3'd0);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (in_range_i) begin
            spd_d   = !op_i;
            state_d = S_ERR;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_ERR: begin
        ctrl_o.load_err = 1'b1;
        state_d         = S_BAND;
      end
      S_BAND: begin
        ctrl_o.apply_band = 1'b1;
        step_d            = '0;
        state_d           = S_MAC;
      end
      S_MAC: begin
        ctrl_o.mac_en = 1'b1;
        if (step_q == MAC_LAST) begin
          step_d  = '0;
          state_d = S_SCALE;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_SCALE: begin
        ctrl_o.scale = 1'b1;
        if (!spd_q) begin
          spd_d   = 1'b1;
          state_d = S_ERR;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          ctrl_o.deliver = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/cascaded_position_speed_pid.sv -----
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid
// Per-motor cascaded position/speed PID with dead bands and clamps.
// ----------------------------------------------------------------------------
// Usage:
// - Command channel (in_valid_i / in_stall_o): one beat carries operation,
//   motor index, goal and feedback. A beat is taken when valid is high and
//   stall is low. Stall is high while a command is being worked on.
// - Result channel (out_valid_o / out_stall_i): one beat per command with
//   the speed setpoint and the current command. A stalled result holds.
// - Config channel (cfg_valid_i / cfg_ready_o): always ready; write only
//   while no command is in flight.
// A position command runs the position loop and then the speed loop; a speed
// command runs the speed loop only, and a motor index out of range goes
// straight to the result. Each loop pass steps through error, dead band, six
// multiply steps on the one shared 23x18 multiplier, and scaling. A new
// command is taken only once the one in work has been handed off.
// The block takes the next command the cycle after it hands off a result to
// the output register, even while that result still waits to be taken.
// A result whose register is still stalled holds the sequencer until free.
// Reset clears all loop state and loads the default gains and dead bands.
// ----------------------------------------------------------------------------
module cascaded_position_speed_pid import cpsp_pkg::*; #(
  parameter int NUM_MOTORS     = 8,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic        [2:0]            motor_index_i,
  input  logic signed [31:0]           goal_i,
  input  logic signed [15:0]           measured_speed_i,
  input  logic signed [31:0]           measured_position_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           speed_setpoint_o,
  output logic signed [CUR_W-1:0]      current_command_o,
  // config channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [GAIN_W-1:0]     cfg_data_i
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int EXT_W = (IDX_W > 3) ? IDX_W : 3;

  cpsp_ctrl_t ctrl;
  logic       busy;
  logic       start;
  logic       in_range;
  logic       out_free;

  // Config registers
  logic [GAIN_W-1:0] pos_kp_q, pos_ki_q, pos_kd_q, spd_kp_q, spd_ki_q, spd_kd_q;
  logic [BAND_W-1:0] pos_band_q, spd_band_q;

  // Per-motor loop state
  logic signed [ERR_W-1:0]  pos_prev_q [NUM_MOTORS];
  logic signed [PSUM_W-1:0] pos_sum_q  [NUM_MOTORS];
  logic signed [ERR_W-1:0]  spd_prev_q [NUM_MOTORS];
  logic signed [SSUM_W-1:0] spd_sum_q  [NUM_MOTORS];

  // Command and work registers
  logic        [EXT_W-1:0]  idx_ext;
  logic        [IDX_W-1:0]  mot_q;
  logic signed [31:0]       goal_q, mpos_q, setpoint_q;
  logic signed [15:0]       mspd_q;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [PSUM_W-1:0] sum_q, sum_d;
  logic signed [CUR_W-1:0]  cur_q, res_d;

  // Output register
  logic                     out_valid_q;
  logic signed [31:0]       out_setpoint_q;
  logic signed [CUR_W-1:0]  out_cur_q;

  assign start       = in_valid_i && !in_stall_o;
  assign in_stall_o  = busy;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign idx_ext     = EXT_W'(motor_index_i);
  assign in_range    = (32'(motor_index_i) < 32'(NUM_MOTORS));
  assign cfg_ready_o = 1'b1;

  cpsp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .in_range_i (in_range),
    .op_i       (operation_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  // Write config registers, masked to their widths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_kp_q   <= POS_KP_RST;
      pos_ki_q   <= POS_KI_RST;
      pos_kd_q   <= POS_KD_RST;
      pos_band_q <= POS_BAND_RST;
      spd_kp_q   <= SPD_KP_RST;
      spd_ki_q   <= SPD_KI_RST;
      spd_kd_q   <= SPD_KD_RST;
      spd_band_q <= SPD_BAND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cpsp_reg_e'(cfg_index_i))
        REG_POS_KP:   pos_kp_q   <= cfg_data_i;
        REG_POS_KI:   pos_ki_q   <= cfg_data_i;
        REG_POS_KD:   pos_kd_q   <= cfg_data_i;
        REG_POS_BAND: pos_band_q <= cfg_data_i[BAND_W-1:0];
        REG_SPD_KP:   spd_kp_q   <= cfg_data_i;
        REG_SPD_KI:   spd_ki_q   <= cfg_data_i;
        REG_SPD_KD:   spd_kd_q   <= cfg_data_i;
        REG_SPD_BAND: spd_band_q <= cfg_data_i[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Raw error of the active loop
  always_comb begin
    if (ctrl.spd_loop) begin
      err_d = ERR_W'(setpoint_q) - ERR_W'(mspd_q);
    end else begin
      err_d = ERR_W'(goal_q) - ERR_W'(mpos_q);
    end
  end

  // Dead band, derivative and clamped integral
  logic signed [DIFF_W-1:0] err_x, band_s, sum_raw, ilim_s;
  logic signed [ERR_W-1:0]  err_db, prev_sel;
  logic signed [PSUM_W-1:0] sum_old;
  logic                     in_band;

  always_comb begin
    err_x    = DIFF_W'(err_q);
    band_s   = $signed({{(DIFF_W-BAND_W){1'b0}},
                        (ctrl.spd_loop ? spd_band_q : pos_band_q)});
    in_band  = (err_x < band_s) && (err_x > -band_s);
    err_db   = in_band ? '0 : err_q;
    prev_sel = ctrl.spd_loop ? spd_prev_q[mot_q] : pos_prev_q[mot_q];
    sum_old  = ctrl.spd_loop ? PSUM_W'(spd_sum_q[mot_q]) : pos_sum_q[mot_q];
    diff_d   = DIFF_W'(err_db) - DIFF_W'(prev_sel);
    sum_raw  = DIFF_W'(sum_old) + DIFF_W'(err_db);
    ilim_s   = ctrl.spd_loop ? DIFF_W'(SPD_INT_LIM) : DIFF_W'(POS_INT_LIM);
    if (sum_raw > ilim_s) begin
      sum_d = PSUM_W'(ilim_s);
    end else if (sum_raw < -ilim_s) begin
      sum_d = PSUM_W'(-ilim_s);
    end else begin
      sum_d = PSUM_W'(sum_raw);
    end
  end

  // Update per-motor state when the dead band is applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        pos_prev_q[m] <= '0;
        pos_sum_q[m]  <= '0;
        spd_prev_q[m] <= '0;
        spd_sum_q[m]  <= '0;
      end
    end else if (ctrl.apply_band) begin
      if (ctrl.spd_loop) begin
        spd_prev_q[mot_q] <= err_db;
        spd_sum_q[mot_q]  <= SSUM_W'(sum_d);
      end else begin
        pos_prev_q[mot_q] <= err_db;
        pos_sum_q[mot_q]  <= sum_d;
      end
    end
  end

  // Select gain and operand for the shared multiplier
  logic        [GAIN_W-1:0] gain_sel;
  logic signed [DIFF_W-1:0] opnd_sel;

  always_comb begin
    case (ctrl.term)
      TERM_P: begin
        gain_sel = ctrl.spd_loop ? spd_kp_q : pos_kp_q;
        opnd_sel = DIFF_W'(err_q);
      end
      TERM_I: begin
        gain_sel = ctrl.spd_loop ? spd_ki_q : pos_ki_q;
        opnd_sel = DIFF_W'(sum_q);
      end
      TERM_D: begin
        gain_sel = ctrl.spd_loop ? spd_kd_q : pos_kd_q;
        opnd_sel = diff_q;
      end
      default: begin
        gain_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  logic signed [ACC_W-1:0] acc;

  cpsp_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .gain_i    (gain_sel),
    .operand_i (opnd_sel),
    .acc_o     (acc)
  );

  // Shift toward zero and clamp to the loop output limit
  logic        [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  acc_adj, q_full, olim_s;

  always_comb begin
    bias    = {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{acc[ACC_W-1]}}};
    acc_adj = acc + $signed(bias);
    q_full  = acc_adj >>> GAIN_FRAC_BITS;
    olim_s  = ctrl.spd_loop ? ACC_W'(CUR_LIM) : ACC_W'(POS_OUT_LIM);
    if (q_full > olim_s) begin
      res_d = CUR_W'(olim_s);
    end else if (q_full < -olim_s) begin
      res_d = CUR_W'(-olim_s);
    end else begin
      res_d = CUR_W'(q_full);
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      mot_q      <= idx_ext[IDX_W-1:0];
      goal_q     <= goal_i;
      mspd_q     <= measured_speed_i;
      mpos_q     <= measured_position_i;
      setpoint_q <= in_range ? goal_i : '0;
      cur_q      <= '0;
    end
    if (ctrl.load_err) begin
      err_q <= err_d;
    end
    if (ctrl.apply_band) begin
      err_q  <= err_db;
      diff_q <= diff_d;
      sum_q  <= sum_d;
    end
    if (ctrl.scale) begin
      if (ctrl.spd_loop) begin
        cur_q <= res_d;
      end else begin
        setpoint_q <= 32'(res_d);
      end
    end
  end

  // Output register: load on hand-off, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.deliver) begin
      out_setpoint_q <= setpoint_q;
      out_cur_q      <= cur_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign speed_setpoint_o  = out_setpoint_q;
  assign current_command_o = out_cur_q;

endmodule

// ----- rtl/core/cpsp_checker.sv -----
// ----------------------------------------------------------------------------
// cpsp_checker
// Port-level assertions for the cascaded position/speed PID block.
// ----------------------------------------------------------------------------
`include "cascaded_position_speed_pid_macros.svh"

module cpsp_checker import cpsp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [CUR_W-1:0] current_command_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Busy right after a command beat
  `CPSP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o, "not busy after accept")

  // No result appears in the cycle after a command beat
  `CPSP_ASSERT_NXT(a_no_early_result, clk_i, rst_ni, in_acc, !$rose(out_valid_o), "result too early")

  // Current command stays within its limit
  `CPSP_ASSERT_IMP(a_cur_limit, clk_i, rst_ni, out_valid_o, (current_command_o <= 15'sd10000) && (current_command_o >= -15'sd10000), "current out of range")

  // A stalled result beat stays valid
  `CPSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped under stall")

endmodule

bind cascaded_position_speed_pid cpsp_checker u_cpsp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .current_command_o (current_command_o)
);
